FILE: rtl/mcfe_pkg.sv
// Package for the motor command frame encoder.
// Holds the command codes, the Q16.16 limits of the MIT fields and the stage enable type.
// No dependencies.
package mcfe_pkg;

   localparam int Q_W = 32;
   localparam longint Q_ONE = 64'sd65536;

   typedef enum logic [3:0] {
      OP_DUTY      = 4'd0,
      OP_CURRENT   = 4'd1,
      OP_BRAKE     = 4'd2,
      OP_RPM       = 4'd3,
      OP_POS       = 4'd4,
      OP_ORIGIN    = 4'd5,
      OP_POS_SPEED = 4'd6,
      OP_RUN       = 4'd7,
      OP_IDLE      = 4'd8,
      OP_ZERO      = 4'd9,
      OP_MIT       = 4'd10
   } op_type;

   localparam logic [16:0] SCALE_DUTY    = 17'd100000;
   localparam logic [16:0] SCALE_CURRENT = 17'd1000;
   localparam logic [16:0] SCALE_RPM     = 17'd1;
   localparam logic [16:0] SCALE_POS     = 17'd10000;

   // Reciprocal of ten for 16-bit magnitudes: x / 10 == (x * RECIP_TEN) >> RECIP_TEN_SHIFT.
   localparam logic [15:0] RECIP_TEN       = 16'd52429;
   localparam int          RECIP_TEN_SHIFT = 19;

   localparam logic [7:0] TAIL_RUN  = 8'hfc;
   localparam logic [7:0] TAIL_IDLE = 8'hfd;
   localparam logic [7:0] TAIL_ZERO = 8'hfe;

   // Each span equals DIV << SHIFT, which splits the exact division in two.
   localparam longint POS_LIM   = 12 * Q_ONE + Q_ONE / 2;
   localparam int     POS_SHIFT = 16;
   localparam int     POS_DIV   = 25;
   localparam longint VEL_LIM   = 45 * Q_ONE;
   localparam int     VEL_SHIFT = 17;
   localparam int     VEL_DIV   = 45;
   localparam longint KP_LIM    = 500 * Q_ONE;
   localparam int     KP_SHIFT  = 18;
   localparam int     KP_DIV    = 125;
   localparam longint KD_LIM    = 5 * Q_ONE;
   localparam int     KD_SHIFT  = 16;
   localparam int     KD_DIV    = 5;
   localparam longint TRQ_LIM   = 18 * Q_ONE;
   localparam int     TRQ_SHIFT = 18;
   localparam int     TRQ_DIV   = 9;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
   } stage_en_type;

endpackage

FILE: rtl/motor_command_frame_encoder.sv
// Motor command frame encoder: turns one motor command into one CAN frame.
// Depends on mcfe_pkg and mcfe_mit_field.
//
//   Channel  Direction  Contents
//   req_     in         motor command, op in tuser, operands in tdata
//   rsp_     out        CAN frame, extended flag in tuser, id, length and data in tdata
//
// Every command passes four register stages; the fourth is the output register.
// One command can be taken in every cycle unless an output stall has filled the pipeline.
// Each stage moves on when it is empty or the stage after it moves, so a stall
// on the output fills the pipeline before req_tready falls.
// Reset clears the valid bits only. Commands with an unknown op are taken and dropped.
module motor_command_frame_encoder
   import mcfe_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // motor_id, value, position, speed, accel, velocity, stiffness, damping, torque_ff
   input  logic [231:0] req_tdata,
   // op
   input  logic [3:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // frame_id, length, payload
   output logic [103:0] rsp_tdata,
   // extended
   output logic [0:0]   rsp_tuser
);

   op_type               op_in;
   logic [7:0]           cid_in;
   logic signed [31:0]   value_in, position_in, velocity_in, torque_in;
   logic signed [15:0]   speed_in, accel_in;
   logic [30:0]          stiffness_in, damping_in;

   stage_en_type         stage_en;
   logic                 out_en;

   logic                 s1_valid_ff, s2_valid_ff, s3_valid_ff, out_valid_ff;
   op_type               s1_op_ff, s2_op_ff, s3_op_ff;
   logic [7:0]           s1_cid_ff, s2_cid_ff, s3_cid_ff;

   logic signed [31:0]   servo_q;
   logic [16:0]          servo_k;
   logic signed [49:0]   s1_prod_in, s1_prod_ff;
   logic [15:0]          spd_mag, acc_mag;
   logic [31:0]          s1_spd_prod_ff, s1_acc_prod_ff;
   logic                 s1_spd_neg_ff, s1_acc_neg_ff;

   logic signed [49:0]   servo_adj;
   logic signed [33:0]   s2_servo_ff;
   logic [12:0]          s2_spd_ff, s2_acc_ff;
   logic                 s2_spd_neg_ff, s2_acc_neg_ff;

   logic [31:0]          s3_sat_in, s3_sat_ff;
   logic [15:0]          s3_spd_ff, s3_acc_ff;

   logic [15:0]          mit_pos;
   logic [11:0]          mit_vel, mit_kp, mit_kd, mit_trq;

   logic [28:0]          id_in, id_ff;
   logic                 ext_in, ext_ff;
   logic [3:0]           len_in, len_ff;
   logic [63:0]          pay_in, pay_ff;

   assign op_in        = op_type'(req_tuser);
   assign cid_in       = req_tdata[7:0];
   assign value_in     = req_tdata[39:8];
   assign position_in  = req_tdata[71:40];
   assign speed_in     = req_tdata[87:72];
   assign accel_in     = req_tdata[103:88];
   assign velocity_in  = req_tdata[135:104];
   assign stiffness_in = req_tdata[166:136];
   assign damping_in   = req_tdata[197:167];
   assign torque_in    = req_tdata[229:198];

   assign out_en      = !out_valid_ff || rsp_tready;
   assign stage_en.s3 = !s3_valid_ff || out_en;
   assign stage_en.s2 = !s2_valid_ff || !s3_valid_ff || out_en;
   assign stage_en.s1 = !s1_valid_ff || !s2_valid_ff || !s3_valid_ff || out_en;
   assign req_tready  = stage_en.s1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (stage_en.s1) begin
            s1_valid_ff <= req_tvalid && (op_in <= OP_MIT);
         end
         if (stage_en.s2) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (stage_en.s3) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (out_en) begin
            out_valid_ff <= s3_valid_ff;
         end
      end
   end

   always_comb begin
      servo_q = value_in;
      servo_k = SCALE_RPM;
      case (op_in)
         OP_DUTY: begin
            servo_k = SCALE_DUTY;
         end
         OP_CURRENT, OP_BRAKE: begin
            servo_k = SCALE_CURRENT;
         end
         OP_POS, OP_POS_SPEED: begin
            servo_q = position_in;
            servo_k = SCALE_POS;
         end
         default: begin
            servo_k = SCALE_RPM;
         end
      endcase
      s1_prod_in = servo_q * $signed({1'b0, servo_k});
      spd_mag    = speed_in[15] ? 16'(-speed_in) : 16'(speed_in);
      acc_mag    = accel_in[15] ? 16'(-accel_in) : 16'(accel_in);
   end

   always_ff @(posedge clock) begin
      if (stage_en.s1) begin
         s1_op_ff       <= op_in;
         s1_cid_ff      <= cid_in;
         s1_prod_ff     <= s1_prod_in;
         s1_spd_prod_ff <= spd_mag * RECIP_TEN;
         s1_acc_prod_ff <= acc_mag * RECIP_TEN;
         s1_spd_neg_ff  <= speed_in[15];
         s1_acc_neg_ff  <= accel_in[15];
      end
   end

   assign servo_adj = s1_prod_ff + (s1_prod_ff[49] ? 50'sd65535 : 50'sd0);

   always_ff @(posedge clock) begin
      if (stage_en.s2) begin
         s2_op_ff      <= s1_op_ff;
         s2_cid_ff     <= s1_cid_ff;
         s2_servo_ff   <= servo_adj[49:16];
         s2_spd_ff     <= s1_spd_prod_ff[RECIP_TEN_SHIFT+12:RECIP_TEN_SHIFT];
         s2_acc_ff     <= s1_acc_prod_ff[RECIP_TEN_SHIFT+12:RECIP_TEN_SHIFT];
         s2_spd_neg_ff <= s1_spd_neg_ff;
         s2_acc_neg_ff <= s1_acc_neg_ff;
      end
   end

   always_comb begin
      if (s2_servo_ff > 34'sd2147483647) begin
         s3_sat_in = 32'h7fff_ffff;
      end else if (s2_servo_ff < -34'sd2147483648) begin
         s3_sat_in = 32'h8000_0000;
      end else begin
         s3_sat_in = s2_servo_ff[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en.s3) begin
         s3_op_ff  <= s2_op_ff;
         s3_cid_ff <= s2_cid_ff;
         s3_sat_ff <= s3_sat_in;
         s3_spd_ff <= s2_spd_neg_ff ? 16'(-{3'b000, s2_spd_ff}) : {3'b000, s2_spd_ff};
         s3_acc_ff <= s2_acc_neg_ff ? 16'(-{3'b000, s2_acc_ff}) : {3'b000, s2_acc_ff};
      end
   end

   mcfe_mit_field #(
      .LO(-POS_LIM), .HI(POS_LIM), .BITS(16), .SHIFT(POS_SHIFT), .DIV(POS_DIV)
   ) u_pos (
      .clock(clock), .stage_en(stage_en), .x(position_in), .q(mit_pos)
   );

   mcfe_mit_field #(
      .LO(-VEL_LIM), .HI(VEL_LIM), .BITS(12), .SHIFT(VEL_SHIFT), .DIV(VEL_DIV)
   ) u_vel (
      .clock(clock), .stage_en(stage_en), .x(velocity_in), .q(mit_vel)
   );

   mcfe_mit_field #(
      .LO(64'sd0), .HI(KP_LIM), .BITS(12), .SHIFT(KP_SHIFT), .DIV(KP_DIV)
   ) u_kp (
      .clock(clock), .stage_en(stage_en), .x($signed({1'b0, stiffness_in})), .q(mit_kp)
   );

   mcfe_mit_field #(
      .LO(64'sd0), .HI(KD_LIM), .BITS(12), .SHIFT(KD_SHIFT), .DIV(KD_DIV)
   ) u_kd (
      .clock(clock), .stage_en(stage_en), .x($signed({1'b0, damping_in})), .q(mit_kd)
   );

   mcfe_mit_field #(
      .LO(-TRQ_LIM), .HI(TRQ_LIM), .BITS(12), .SHIFT(TRQ_SHIFT), .DIV(TRQ_DIV)
   ) u_trq (
      .clock(clock), .stage_en(stage_en), .x(torque_in), .q(mit_trq)
   );

   always_comb begin
      id_in  = (s3_op_ff <= OP_POS_SPEED) ? 29'({s3_op_ff, s3_cid_ff}) : 29'(s3_cid_ff);
      ext_in = 1'b1;
      len_in = 4'd8;
      pay_in = 64'd0;
      case (s3_op_ff)
         OP_DUTY, OP_CURRENT, OP_BRAKE, OP_RPM, OP_POS: begin
            len_in = 4'd4;
            pay_in = {s3_sat_ff, 32'd0};
         end
         OP_ORIGIN: begin
            len_in = 4'd0;
         end
         OP_POS_SPEED: begin
            pay_in = {s3_sat_ff, s3_spd_ff, s3_acc_ff};
         end
         OP_RUN: begin
            pay_in = {56'hff_ffff_ffff_ffff, TAIL_RUN};
         end
         OP_IDLE: begin
            pay_in = {56'hff_ffff_ffff_ffff, TAIL_IDLE};
         end
         OP_ZERO: begin
            pay_in = {56'hff_ffff_ffff_ffff, TAIL_ZERO};
         end
         OP_MIT: begin
            ext_in = 1'b0;
            pay_in = {mit_pos, mit_vel, mit_kp, mit_kd, mit_trq};
         end
         default: begin
            len_in = 4'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (out_en) begin
         id_ff  <= id_in;
         ext_ff <= ext_in;
         len_ff <= len_in;
         pay_ff <= pay_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, pay_ff, len_ff, id_ff};
   assign rsp_tuser  = ext_ff;

endmodule

FILE: rtl/mcfe_mit_field.sv
// Three-stage scaler for one MIT field: clamp, scale to BITS bits, exact floor division.
// Depends on mcfe_pkg.
module mcfe_mit_field
   import mcfe_pkg::*;
#(
   parameter longint LO    = -POS_LIM,
   parameter longint HI    = POS_LIM,
   parameter int     BITS  = 16,
   parameter int     SHIFT = POS_SHIFT,
   parameter int     DIV   = POS_DIV
)(
   input  logic                   clock,
   input  stage_en_type           stage_en,
   input  logic signed [Q_W-1:0]  x,
   output logic [BITS-1:0]        q
);

   localparam longint SPAN = HI - LO;
   localparam int     DW   = $clog2(SPAN + 1);
   localparam int     WW   = DW + BITS;
   localparam int     MW   = WW - SHIFT;
   localparam int     K    = MW + 8;
   localparam longint MUL  = ((64'sd1 <<< K) + DIV - 1) / DIV;
   localparam int     MULW = $clog2(MUL + 1);
   localparam int     PW   = MW + MULW;
   localparam int     CW   = Q_W + 2;

   localparam logic signed [CW-1:0] LO_C  = CW'(LO);
   localparam logic signed [CW-1:0] HI_C  = CW'(HI);
   localparam logic [MULW-1:0]      MUL_C = MULW'(MUL);

   logic signed [CW-1:0] x_ext;
   logic signed [CW-1:0] clamped;
   logic signed [CW-1:0] diff;
   logic [DW-1:0]        d_in, d_ff;
   logic [WW-1:0]        wide;
   logic [MW-1:0]        m_in, m_ff;
   logic [PW-1:0]        prod_in, prod_ff;
   logic [PW-1:0]        shifted;

   always_comb begin
      x_ext = CW'(x);
      if (x_ext < LO_C) begin
         clamped = LO_C;
      end else if (x_ext > HI_C) begin
         clamped = HI_C;
      end else begin
         clamped = x_ext;
      end
      diff = clamped - LO_C;
      d_in = diff[DW-1:0];
   end

   assign wide    = {d_ff, BITS'(0)} - WW'(d_ff);
   assign m_in    = wide[WW-1:SHIFT];
   assign prod_in = PW'(m_ff) * PW'(MUL_C);
   assign shifted = prod_ff >> K;
   assign q       = shifted[BITS-1:0];

   always_ff @(posedge clock) begin
      if (stage_en.s1) begin
         d_ff <= d_in;
      end
      if (stage_en.s2) begin
         m_ff <= m_in;
      end
      if (stage_en.s3) begin
         prod_ff <= prod_in;
      end
   end

endmodule

FILE: tb/motor_command_frame_encoder_tb.sv
// Testbench for motor_command_frame_encoder: drives motor commands and checks each CAN frame
// against a frame predictor inside a small scoreboard class.
// Depends on mcfe_pkg and the encoder RTL.
module motor_command_frame_encoder_tb
   import mcfe_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [3:0]          op;
      logic [7:0]          motor_id;
      logic signed [31:0]  value;
      logic signed [31:0]  position;
      logic signed [15:0]  speed;
      logic signed [15:0]  accel;
      logic signed [31:0]  velocity;
      logic [30:0]         stiffness;
      logic [30:0]         damping;
      logic signed [31:0]  torque_ff;
   } command_type;

   typedef struct {
      logic [28:0] frame_id;
      logic        extended;
      logic [3:0]  length;
      logic [63:0] payload;
   } frame_type;

   class frame_scoreboard;
      frame_type pending_frames[$];
      int        mismatches = 0;

      function automatic logic [31:0] servo_word(longint q, longint k);
         longint r;
         r = (q * k) / Q_ONE;
         if (r > 64'sd2147483647) r = 64'sd2147483647;
         if (r < -64'sd2147483648) r = -64'sd2147483648;
         return r[31:0];
      endfunction

      function automatic longint mit_code(longint x, longint lo, longint hi, int bits);
         if (x < lo) x = lo;
         if (x > hi) x = hi;
         return ((x - lo) * ((longint'(1) << bits) - 1)) / (hi - lo);
      endfunction

      function automatic bit encode_frame(command_type c, output frame_type f);
         int     spd;
         int     acc;
         longint p_code;
         longint v_code;
         longint kp_code;
         longint kd_code;
         longint t_code;
         f.frame_id = 29'(c.motor_id);
         f.extended = 1'b1;
         f.length   = 4'd0;
         f.payload  = 64'd0;
         spd = c.speed;
         acc = c.accel;
         spd = spd / 10;
         acc = acc / 10;
         case (c.op)
            OP_DUTY: begin
               f.length  = 4'd4;
               f.payload = {servo_word(c.value, longint'(SCALE_DUTY)), 32'd0};
            end
            OP_CURRENT, OP_BRAKE: begin
               f.length  = 4'd4;
               f.payload = {servo_word(c.value, longint'(SCALE_CURRENT)), 32'd0};
            end
            OP_RPM: begin
               f.length  = 4'd4;
               f.payload = {servo_word(c.value, longint'(SCALE_RPM)), 32'd0};
            end
            OP_POS: begin
               f.length  = 4'd4;
               f.payload = {servo_word(c.position, longint'(SCALE_POS)), 32'd0};
            end
            OP_ORIGIN: begin
            end
            OP_POS_SPEED: begin
               f.length  = 4'd8;
               f.payload = {servo_word(c.position, longint'(SCALE_POS)), spd[15:0], acc[15:0]};
            end
            OP_RUN: begin
               f.length  = 4'd8;
               f.payload = {56'hFF_FFFF_FFFF_FFFF, TAIL_RUN};
            end
            OP_IDLE: begin
               f.length  = 4'd8;
               f.payload = {56'hFF_FFFF_FFFF_FFFF, TAIL_IDLE};
            end
            OP_ZERO: begin
               f.length  = 4'd8;
               f.payload = {56'hFF_FFFF_FFFF_FFFF, TAIL_ZERO};
            end
            OP_MIT: begin
               p_code  = mit_code(c.position, -POS_LIM, POS_LIM, 16);
               v_code  = mit_code(c.velocity, -VEL_LIM, VEL_LIM, 12);
               kp_code = mit_code(longint'(c.stiffness), 0, KP_LIM, 12);
               kd_code = mit_code(longint'(c.damping), 0, KD_LIM, 12);
               t_code  = mit_code(c.torque_ff, -TRQ_LIM, TRQ_LIM, 12);
               f.extended = 1'b0;
               f.length   = 4'd8;
               f.payload  = {p_code[15:0], v_code[11:0], kp_code[11:0], kd_code[11:0],
                             t_code[11:0]};
            end
            default: return 1'b0;
         endcase
         if (c.op <= OP_POS_SPEED) f.frame_id = 29'({c.op, c.motor_id});
         return 1'b1;
      endfunction

      function void note_command(command_type c);
         frame_type f;
         if (encode_frame(c, f)) pending_frames.push_back(f);
      endfunction

      function void check_frame(frame_type got);
         frame_type want;
         if (pending_frames.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected frame id %h ext %b len %0d data %h",
                        $realtime, got.frame_id, got.extended, got.length, got.payload);
            return;
         end
         want = pending_frames.pop_front();
         if (got.frame_id !== want.frame_id || got.extended !== want.extended ||
             got.length !== want.length || got.payload !== want.payload) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: frame mismatch", $realtime);
               $display("   expected id %h ext %b len %0d data %h",
                        want.frame_id, want.extended, want.length, want.payload);
               $display("   actual   id %h ext %b len %0d data %h",
                        got.frame_id, got.extended, got.length, got.payload);
            end
         end
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [231:0] req_tdata = '0;
   logic [3:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [103:0] rsp_tdata;
   logic [0:0]   rsp_tuser;

   frame_scoreboard sb;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   motor_command_frame_encoder DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #200_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      forever begin
         @(negedge clock);
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      frame_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.frame_id = rsp_tdata[28:0];
         got.length   = rsp_tdata[32:29];
         got.payload  = rsp_tdata[96:33];
         got.extended = rsp_tuser[0];
         sb.check_frame(got);
      end
   end

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_command(input command_type c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= c.op;
      req_tdata  <= {2'b00, c.torque_ff, c.damping, c.stiffness, c.velocity, c.accel,
                     c.speed, c.position, c.value, c.motor_id};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_command(c);
      @(negedge clock);
   endtask

   function automatic command_type blank_command(logic [3:0] op, logic [7:0] cid);
      command_type c;
      c.op        = op;
      c.motor_id  = cid;
      c.value     = '0;
      c.position  = '0;
      c.speed     = '0;
      c.accel     = '0;
      c.velocity  = '0;
      c.stiffness = '0;
      c.damping   = '0;
      c.torque_ff = '0;
      return c;
   endfunction

   // Signed Q16.16 value: full range, near a limit, or inside twice the limit.
   function automatic logic [31:0] random_q(longint lim);
      longint r;
      case ($urandom_range(3))
         0: r = longint'($signed($urandom()));
         1: r = (($urandom_range(1) != 0) ? lim : -lim) + longint'($urandom_range(2)) - 1;
         default: r = longint'($urandom_range(32'(4 * lim))) - 2 * lim;
      endcase
      return r[31:0];
   endfunction

   function automatic logic [30:0] random_gain(longint lim);
      longint r;
      case ($urandom_range(3))
         0: r = longint'($urandom() & 32'h7fff_ffff);
         1: r = (($urandom_range(1) != 0) ? lim : 0) + longint'($urandom_range(2)) - 1;
         default: r = longint'($urandom_range(32'(2 * lim)));
      endcase
      if (r < 0) r = 0;
      return r[30:0];
   endfunction

   function automatic logic [15:0] random_rate();
      if ($urandom_range(3) == 0) return 16'($signed($urandom_range(40)) - 20);
      return 16'($urandom());
   endfunction

   function automatic command_type random_command();
      command_type c;
      if ($urandom_range(99) < 6)
         c.op = 4'($urandom_range(15, int'(OP_MIT) + 1));
      else
         c.op = 4'($urandom_range(int'(OP_MIT)));
      c.motor_id  = 8'($urandom());
      c.value     = random_q(longint'(1) << 22);
      c.position  = random_q(POS_LIM);
      c.speed     = random_rate();
      c.accel     = random_rate();
      c.velocity  = random_q(VEL_LIM);
      c.stiffness = random_gain(KP_LIM);
      c.damping   = random_gain(KD_LIM);
      c.torque_ff = random_q(TRQ_LIM);
      return c;
   endfunction

   initial begin
      command_type c;
      sb = new;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Servo saturation at both ends and truncation toward zero.
      c = blank_command(OP_DUTY, 8'h00);      c.value = 32'h7fff_ffff;       send_command(c);
      c = blank_command(OP_DUTY, 8'hff);      c.value = 32'h8000_0000;       send_command(c);
      c = blank_command(OP_CURRENT, 8'h01);   c.value = 32'hffff_ffff;       send_command(c);
      c = blank_command(OP_BRAKE, 8'h80);     c.value = 32'h0001_8000;       send_command(c);
      c = blank_command(OP_RPM, 8'h7f);       c.value = 32'h8000_0000;       send_command(c);
      c = blank_command(OP_RPM, 8'h55);       c.value = 32'h7fff_ffff;       send_command(c);
      c = blank_command(OP_POS, 8'haa);       c.position = 32'h7fff_ffff;    send_command(c);
      c = blank_command(OP_ORIGIN, 8'hff);
      c.value = '1; c.position = '1; c.speed = '1; c.accel = '1;
      send_command(c);
      c = blank_command(OP_POS_SPEED, 8'h12);
      c.position = 32'h8000_0000; c.speed = 16'h8000; c.accel = 16'h7fff;
      send_command(c);
      c = blank_command(OP_POS_SPEED, 8'h34);
      c.position = 32'hfff0_0000; c.speed = -16'sd9; c.accel = 16'sd9;
      send_command(c);
      c = blank_command(OP_RUN, 8'hff);       send_command(c);
      c = blank_command(OP_IDLE, 8'h00);      send_command(c);
      c = blank_command(OP_ZERO, 8'h5a);      send_command(c);
      // MIT clamping below, above, exactly at the limits, and the midpoint.
      c = blank_command(OP_MIT, 8'h01);
      c.position = 32'h8000_0000; c.velocity = 32'h8000_0000; c.torque_ff = 32'h8000_0000;
      send_command(c);
      c = blank_command(OP_MIT, 8'hfe);
      c.position = 32'h7fff_ffff; c.velocity = 32'h7fff_ffff; c.torque_ff = 32'h7fff_ffff;
      c.stiffness = '1; c.damping = '1;
      send_command(c);
      c = blank_command(OP_MIT, 8'h42);
      c.position = 32'(POS_LIM); c.velocity = 32'(-VEL_LIM); c.torque_ff = 32'(TRQ_LIM);
      c.stiffness = 31'(KP_LIM); c.damping = 31'(KD_LIM);
      send_command(c);
      c = blank_command(OP_MIT, 8'h24);       send_command(c);
      for (int k = int'(OP_MIT) + 1; k < 16; k++) begin
         c = blank_command(4'(k), 8'(k));
         send_command(c);
      end

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 79 : 0;
         recv_idle_pct = (phase == 0) ? 79 : (phase == 1) ? 31 : 0;
         repeat (135) send_command(random_command());
      end
      req_tvalid <= 1'b0;

      while (sb.pending_frames.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.mismatches == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
